### rtl/hpt_pkg.sv
// Shared types, constants and codes for the homogeneous point transform.
package hpt_pkg;

    localparam int MAX_DIM       = 4;
    localparam int DIM_DEF       = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int IDX_W         = 2;
    localparam int REQ_W         = 2;
    localparam int S_TDATA_W     = 168;
    localparam int S_TUSER_W     = 8;
    localparam int M_TDATA_W     = MAX_DIM * COORD_W;

    typedef logic signed [COORD_W-1:0] fx_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_XFORM = 2'd1,
        REQ_IDENT = 2'd2
    } req_t;

    // Load enables for the three lane stages.
    typedef struct packed {
        logic en_mul;
        logic en_add;
        logic en_sat;
    } lane_ctl_t;

endpackage

### rtl/hpt_lane.sv
// One row lane: four multipliers, a two-level adder tree, then shift and saturate.
module hpt_lane #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  hpt_pkg::lane_ctl_t  ctl,
    input  hpt_pkg::fx_t        row_elem [hpt_pkg::MAX_DIM],
    input  hpt_pkg::fx_t        point    [hpt_pkg::MAX_DIM],
    output hpt_pkg::fx_t        result
);

    localparam logic signed [hpt_pkg::SUM_W-1:0] SAT_MAX =
        hpt_pkg::SUM_W'(64'sd2147483647);
    localparam logic signed [hpt_pkg::SUM_W-1:0] SAT_MIN =
        -hpt_pkg::SUM_W'(64'sd2147483648);

    hpt_pkg::prod_t                        prod_reg [hpt_pkg::MAX_DIM];
    logic signed [hpt_pkg::PROD_W:0]       pair_reg [2];
    logic signed [hpt_pkg::SUM_W-1:0]      total;
    logic signed [hpt_pkg::SUM_W-1:0]      shifted;
    hpt_pkg::fx_t                          result_reg;
    hpt_pkg::fx_t                          result_next;

    always_ff @(posedge aclk) begin
        if (ctl.en_mul) begin
            for (int c = 0; c < hpt_pkg::MAX_DIM; c++) begin
                prod_reg[c] <= row_elem[c] * point[c];
            end
        end
        if (ctl.en_add) begin
            pair_reg[0] <= (hpt_pkg::PROD_W+1)'(prod_reg[0])
                         + (hpt_pkg::PROD_W+1)'(prod_reg[1]);
            pair_reg[1] <= (hpt_pkg::PROD_W+1)'(prod_reg[2])
                         + (hpt_pkg::PROD_W+1)'(prod_reg[3]);
        end
        if (ctl.en_sat) begin
            result_reg <= result_next;
        end
    end

    // The exact sum is shifted arithmetically, which floors it.
    always_comb begin
        total   = hpt_pkg::SUM_W'(pair_reg[0]) + hpt_pkg::SUM_W'(pair_reg[1]);
        shifted = total >>> FRAC_BITS;
        if (shifted > SAT_MAX) begin
            result_next = hpt_pkg::fx_t'(32'h7FFF_FFFF);
        end else if (shifted < SAT_MIN) begin
            result_next = hpt_pkg::fx_t'(32'h8000_0000);
        end else begin
            result_next = shifted[hpt_pkg::COORD_W-1:0];
        end
    end

    assign result = result_reg;

endmodule

### rtl/hpt_merge.sv
// Output stage: gathers the lane results into one item and holds it for the receiver.
module hpt_merge (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  hpt_pkg::fx_t  lane_result [hpt_pkg::MAX_DIM],
    output logic          in_ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    // m_tdata fields from bit 0: out_x, out_y, out_z, out_h
    output logic [hpt_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [hpt_pkg::M_TDATA_W-1:0] data_reg;
    logic [hpt_pkg::M_TDATA_W-1:0] data_next;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = in_valid;
            for (int r = 0; r < hpt_pkg::MAX_DIM; r++) begin
                data_next[r*hpt_pkg::COORD_W +: hpt_pkg::COORD_W] = lane_result[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

### rtl/homogeneous_point_transform.sv
// Top level: matrix store, request decode, row lanes and output stage.
//
// Usage. Items arrive on the s_ channel: s_tuser carries the request kind and
// s_tdata the element index, element value and point. A write request stores one
// matrix element, an identity request reloads the identity matrix, and neither
// gives a result. A transform request gives one item on the m_ channel holding
// the four row dot products of the matrix with the point, floored back to the
// fixed-point format and saturated to 32 bits; rows at or beyond DIM read zero.
// After acceptance a transform passes through the multipliers, the pair adds,
// the final add and saturation, and the output register to m_tvalid. One item
// is taken every cycle while the receiver keeps up; a transform uses the
// matrix as it stands when it is accepted, so a write followed directly by a
// transform is seen by it.
// If the receiver stalls, the pipeline keeps filling its empty stages and
// s_tready falls only once every stage holds a result.
// Reset (aresetn low at a clock edge) empties the pipeline and loads the
// identity matrix.
module homogeneous_point_transform #(
    parameter int DIM       = hpt_pkg::DIM_DEF,
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata fields from bit 0: row, col, elem_value, in_x, in_y, in_z, in_h
    input  logic [hpt_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0: req_type
    input  logic [hpt_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata fields from bit 0: out_x, out_y, out_z, out_h
    output logic [hpt_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int MI_W = (DIM > 2) ? 2 : 1;
    localparam hpt_pkg::fx_t ONE_FX = hpt_pkg::fx_t'(64'sd1 <<< FRAC_BITS);

    hpt_pkg::fx_t        matrix_reg  [DIM][DIM];
    hpt_pkg::fx_t        matrix_next [DIM][DIM];
    hpt_pkg::fx_t        row_elem    [hpt_pkg::MAX_DIM][hpt_pkg::MAX_DIM];
    hpt_pkg::fx_t        point       [hpt_pkg::MAX_DIM];
    hpt_pkg::fx_t        coord       [hpt_pkg::MAX_DIM];
    hpt_pkg::fx_t        lane_result [hpt_pkg::MAX_DIM];
    hpt_pkg::lane_ctl_t  lane_ctl;

    logic [hpt_pkg::IDX_W-1:0] wr_row;
    logic [hpt_pkg::IDX_W-1:0] wr_col;
    hpt_pkg::fx_t              elem_value;
    hpt_pkg::req_t             req_type;
    logic                      accept;

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic can1, can2, can3, out_ready;

    assign wr_row     = s_tdata[1:0];
    assign wr_col     = s_tdata[3:2];
    assign elem_value = s_tdata[35:4];
    assign coord[0]   = s_tdata[67:36];
    assign coord[1]   = s_tdata[99:68];
    assign coord[2]   = s_tdata[131:100];
    assign coord[3]   = s_tdata[163:132];
    assign req_type   = hpt_pkg::req_t'(s_tuser[hpt_pkg::REQ_W-1:0]);

    // Stage enables: a stage loads when it is empty or its successor moves on.
    assign can3     = !v3_reg || out_ready;
    assign can2     = !v2_reg || can3;
    assign can1     = !v1_reg || can2;
    assign s_tready = can1;
    assign accept   = s_tvalid && s_tready;

    assign lane_ctl.en_mul = can1;
    assign lane_ctl.en_add = can2;
    assign lane_ctl.en_sat = can3;

    always_comb begin
        v1_next = can1 ? (accept && req_type == hpt_pkg::REQ_XFORM) : v1_reg;
        v2_next = can2 ? v1_reg : v2_reg;
        v3_next = can3 ? v2_reg : v3_reg;
    end

    always_comb begin
        matrix_next = matrix_reg;
        if (accept) begin
            case (req_type)
                hpt_pkg::REQ_WRITE: begin
                    if (int'(wr_row) < DIM && int'(wr_col) < DIM) begin
                        matrix_next[wr_row[MI_W-1:0]][wr_col[MI_W-1:0]] = elem_value;
                    end
                end
                hpt_pkg::REQ_IDENT: begin
                    for (int r = 0; r < DIM; r++) begin
                        for (int c = 0; c < DIM; c++) begin
                            matrix_next[r][c] = (r == c) ? ONE_FX : '0;
                        end
                    end
                end
                default: begin
                    matrix_next = matrix_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    matrix_reg[r][c] <= (r == c) ? ONE_FX : '0;
                end
            end
        end else begin
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            v3_reg     <= v3_next;
            matrix_reg <= matrix_next;
        end
    end

    // Lanes and terms beyond DIM are tied to zero.
    for (genvar r = 0; r < hpt_pkg::MAX_DIM; r++) begin : g_row
        for (genvar c = 0; c < hpt_pkg::MAX_DIM; c++) begin : g_col
            if (r < DIM && c < DIM) begin : g_used
                assign row_elem[r][c] = matrix_reg[r][c];
            end else begin : g_unused
                assign row_elem[r][c] = '0;
            end
        end
        if (r < DIM) begin : g_pt
            assign point[r] = coord[r];
        end else begin : g_no_pt
            assign point[r] = '0;
        end
        if (r < DIM) begin : g_lane
            hpt_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .aclk     (aclk),
                .ctl      (lane_ctl),
                .row_elem (row_elem[r]),
                .point    (point),
                .result   (lane_result[r])
            );
        end else begin : g_no_lane
            assign lane_result[r] = '0;
        end
    end

    hpt_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v3_reg),
        .lane_result (lane_result),
        .in_ready    (out_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

### tb/sv/hpt_result_monitor.sv
`timescale 1ns / 1ps
// Result monitor: tracks the matrix, predicts transform results and compares them.
module hpt_result_monitor #(
    parameter int DIM       = hpt_pkg::DIM_DEF,
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [hpt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [hpt_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [hpt_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                             fail_count,
    output int                             pending
);

    localparam int ROW_LSB  = 0;
    localparam int COL_LSB  = hpt_pkg::IDX_W;
    localparam int ELEM_LSB = 2 * hpt_pkg::IDX_W;
    localparam int PT_LSB   = ELEM_LSB + hpt_pkg::COORD_W;
    localparam int PT_W     = hpt_pkg::MAX_DIM * hpt_pkg::COORD_W;
    localparam int CW       = hpt_pkg::COORD_W;

    localparam logic signed [hpt_pkg::SUM_W-1:0] FX_MAX = hpt_pkg::SUM_W'(32'h7fff_ffff);
    localparam logic signed [hpt_pkg::SUM_W-1:0] FX_MIN = -FX_MAX - 1;

    string field_names [hpt_pkg::MAX_DIM] = '{"out_x", "out_y", "out_z", "out_h"};

    hpt_pkg::fx_t                  mat [hpt_pkg::MAX_DIM][hpt_pkg::MAX_DIM];
    logic [hpt_pkg::M_TDATA_W-1:0] expected_points [$];

    task automatic load_identity();
        for (int r = 0; r < hpt_pkg::MAX_DIM; r++) begin
            for (int c = 0; c < hpt_pkg::MAX_DIM; c++) begin
                mat[r][c] = (r == c && r < DIM) ? hpt_pkg::fx_t'(1) <<< FRAC_BITS
                                                : hpt_pkg::fx_t'(0);
            end
        end
    endtask

    // Exact dot product, floored back to the fixed-point format, then clamped.
    function automatic hpt_pkg::fx_t row_product(input int r, input logic [PT_W-1:0] pt);
        logic signed [hpt_pkg::SUM_W-1:0] acc;
        hpt_pkg::prod_t                   p;
        hpt_pkg::fx_t                     v;
        acc = '0;
        for (int c = 0; c < DIM; c++) begin
            v   = pt[c*CW +: CW];
            p   = mat[r][c] * v;
            acc = acc + p;
        end
        acc = acc >>> FRAC_BITS;
        if (acc > FX_MAX) begin
            acc = FX_MAX;
        end else if (acc < FX_MIN) begin
            acc = FX_MIN;
        end
        return acc[CW-1:0];
    endfunction

    function automatic logic [hpt_pkg::M_TDATA_W-1:0] transform_point(
        input logic [PT_W-1:0] pt);
        logic [hpt_pkg::M_TDATA_W-1:0] res;
        res = '0;
        for (int r = 0; r < DIM; r++) begin
            res[r*CW +: CW] = row_product(r, pt);
        end
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        logic [hpt_pkg::M_TDATA_W-1:0] want;
        logic [hpt_pkg::IDX_W-1:0]     row;
        logic [hpt_pkg::IDX_W-1:0]     col;
        logic                          bad;
        if (!aresetn) begin
            load_identity();
            expected_points.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                row = s_tdata[ROW_LSB +: hpt_pkg::IDX_W];
                col = s_tdata[COL_LSB +: hpt_pkg::IDX_W];
                case (hpt_pkg::req_t'(s_tuser[hpt_pkg::REQ_W-1:0]))
                    hpt_pkg::REQ_WRITE: begin
                        if (row < DIM && col < DIM) begin
                            mat[row][col] = s_tdata[ELEM_LSB +: CW];
                        end
                    end
                    hpt_pkg::REQ_XFORM: begin
                        expected_points.push_back(transform_point(s_tdata[PT_LSB +: PT_W]));
                    end
                    hpt_pkg::REQ_IDENT: load_identity();
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%t: result item %h arrived with nothing expected",
                                 $realtime, m_tdata);
                    end
                    fail_count++;
                end else begin
                    want = expected_points.pop_front();
                    bad  = 1'b0;
                    for (int f = 0; f < hpt_pkg::MAX_DIM; f++) begin
                        if (m_tdata[f*CW +: CW] !== want[f*CW +: CW]) begin
                            if (fail_count < 10) begin
                                $display("%t: %s expected %h, got %h", $realtime,
                                         field_names[f], want[f*CW +: CW],
                                         m_tdata[f*CW +: CW]);
                            end
                            bad = 1'b1;
                        end
                    end
                    if (bad) begin
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_points.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, item stimulus and the final verdict for the transform.
module tb;

    localparam int DIM        = hpt_pkg::DIM_DEF;
    localparam int FRAC_BITS  = hpt_pkg::FRAC_BITS_DEF;
    localparam int NUM_RANDOM = 930;

    // Request code that the block does not use.
    localparam logic [hpt_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [hpt_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [hpt_pkg::S_TUSER_W-1:0]  s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [hpt_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           idle_on  = 1'b0;
    int                             fail_count;
    int                             pending;

    always #10 aclk = ~aclk;

    homogeneous_point_transform #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hpt_result_monitor #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The receiver stalls at random only while idling is switched on.
    always @(negedge aclk) begin
        m_tready = aresetn && (!idle_on || $urandom_range(99) >= 22);
    end

    // A mix of modest values, small whole numbers, full-range random values and the two extremes.
    function automatic hpt_pkg::fx_t rand_fx();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2, 3, 4: return hpt_pkg::fx_t'($urandom_range(32'h000f_ffff)) - 32'sh0008_0000;
            5:       return (hpt_pkg::fx_t'($urandom_range(8)) - 4) <<< FRAC_BITS;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [hpt_pkg::IDX_W-1:0] rand_idx();
        return hpt_pkg::IDX_W'($urandom);
    endfunction

    task automatic send_item(input logic [hpt_pkg::REQ_W-1:0] req,
                             input logic [hpt_pkg::IDX_W-1:0] row,
                             input logic [hpt_pkg::IDX_W-1:0] col, input hpt_pkg::fx_t val,
                             input hpt_pkg::fx_t x, input hpt_pkg::fx_t y,
                             input hpt_pkg::fx_t z, input hpt_pkg::fx_t h);
        while (idle_on && $urandom_range(99) < 22) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = hpt_pkg::S_TDATA_W'({h, z, y, x, val, col, row});
        s_tuser  = hpt_pkg::S_TUSER_W'(req);
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_elem(input logic [hpt_pkg::IDX_W-1:0] row,
                              input logic [hpt_pkg::IDX_W-1:0] col, input hpt_pkg::fx_t val);
        send_item(hpt_pkg::REQ_WRITE, row, col, val, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic xform(input hpt_pkg::fx_t x, input hpt_pkg::fx_t y, input hpt_pkg::fx_t z,
                         input hpt_pkg::fx_t h);
        send_item(hpt_pkg::REQ_XFORM, rand_idx(), rand_idx(), $urandom, x, y, z, h);
    endtask

    initial begin : stimulus
        int k;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Identity after reset, with extreme coordinates.
        xform(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001, 32'shffff_ffff);
        send_item(REQ_UNUSED, rand_idx(), rand_idx(), $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        for (int c = 0; c < 4; c++) begin
            write_elem(2'd0, hpt_pkg::IDX_W'(c), 32'sh7fff_ffff);
        end
        for (int c = 0; c < 4; c++) begin
            write_elem(2'd1, hpt_pkg::IDX_W'(c), 32'sh8000_0000);
        end
        write_elem(2'd2, 2'd0, 32'shffff_ffff);
        write_elem(2'd2, 2'd1, 32'sh0000_0001);
        write_elem(2'd2, 2'd2, 32'sh0001_0000);
        write_elem(2'd2, 2'd3, 32'sh0000_0000);
        write_elem(2'd3, 2'd3, 32'sh8000_0000);
        // Saturation both ways, then flooring of small negative products.
        xform(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        xform(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        xform(32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        xform(32'shffff_ffff, 32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000);
        send_item(hpt_pkg::REQ_IDENT, rand_idx(), rand_idx(), $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        // A write directly followed by a transform must be seen by it.
        write_elem(2'd1, 2'd2, 32'sh0001_8000);
        xform(32'sh0001_0000, 32'sh0002_0000, 32'shfffd_0000, 32'sh0001_0000);
        send_item(REQ_UNUSED, 2'd3, 2'd3, '1, '1, '1, '1, '1);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            idle_on = (i >= 300);
            if (i == 600) begin
                s_tvalid = 1'b0;
                while (pending != 0) @(negedge aclk);
            end
            k = $urandom_range(99);
            if (k < 45) begin
                xform(rand_fx(), rand_fx(), rand_fx(), rand_fx());
            end else if (k < 87) begin
                write_elem(rand_idx(), rand_idx(), rand_fx());
            end else if (k < 94) begin
                send_item(hpt_pkg::REQ_IDENT, rand_idx(), rand_idx(), $urandom, $urandom,
                          $urandom, $urandom, $urandom);
            end else begin
                send_item(REQ_UNUSED, rand_idx(), rand_idx(), $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            end
        end

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
rtl/hpt_pkg.sv
rtl/hpt_lane.sv
rtl/hpt_merge.sv
rtl/homogeneous_point_transform.sv
tb/sv/hpt_result_monitor.sv
tb/sv/tb.sv
